// File: design/sbfc_pkg.sv
// Package for the complex symmetric bilinear form block.
// Holds sizes, status codes, command and status structs and arithmetic helpers.
// Depends on nothing.
package sbfc_pkg;

   localparam int MAX_DIM   = 64;
   localparam int DIM_W     = 7;
   localparam int IDX_W     = 6;
   localparam int TRI_DEPTH = MAX_DIM * (MAX_DIM + 1) / 2;
   localparam int TRI_W     = 12;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSION     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIAGONAL_ONLY = 1'd1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH  = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   localparam logic [0:0] KIND_MATRIX  = 1'b0;
   localparam logic [0:0] KIND_ELEMENT = 1'b1;

   typedef struct packed {
      logic             load;
      logic             elem;
      logic             store;
      logic [IDX_W-1:0] m;
      logic             issue;
      logic             diag;
      logic [IDX_W-1:0] k;
      logic             finish;
      logic             mismatch;
   } sbfc_cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic out_busy;
   } sbfc_status_type;

   // Start of row r in the packed lower triangle: r*(r+1)/2.
   function automatic logic [TRI_W-1:0] tri_base(input logic [IDX_W-1:0] r);
      logic [TRI_W:0] p;
      p = {7'd0, r} * ({7'd0, r} + 13'd1);
      return p[TRI_W:1];
   endfunction

   // Clamp a 65-bit sum to 64 bits; the top bit of the result flags a clamp.
   function automatic logic [64:0] sat65(input logic signed [64:0] v);
      logic [64:0] r;
      if (v[64] != v[63]) begin
         r = v[64] ? {1'b1, 1'b1, 63'd0} : {1'b1, 1'b0, {63{1'b1}}};
      end else begin
         r = {1'b0, v[63:0]};
      end
      return r;
   endfunction

endpackage

// File: design/sbfc_ctrl.sv
// Controller of the complex symmetric bilinear form block.
// Sequences matrix loads, element terms and result hand-over; uses sbfc_pkg.
module sbfc_ctrl import sbfc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic                 req_last,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   input  sbfc_status_type      status,
   output sbfc_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_RUN    = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } ctrl_state_type;

   ctrl_state_type   state_ff, state_in;
   logic [DIM_W-1:0] count_ff, count_in;
   logic [DIM_W-1:0] dim_ff, dim_in;
   logic             diag_only_ff, diag_only_in;
   logic [IDX_W-1:0] m_ff, m_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             diag_pend_ff, diag_pend_in;
   logic             last_ff, last_in;
   logic             accept;
   logic             store;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign store     = (count_ff < DIM_W'(MAX_DIM)) && (count_ff < dim_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dim_in       = dim_ff;
      diag_only_in = diag_only_ff;
      m_in         = m_ff;
      k_in         = k_ff;
      diag_pend_in = diag_pend_ff;
      last_in      = last_ff;
      cmd          = '0;
      cmd.m        = count_ff[IDX_W-1:0];
      cmd.k        = k_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DIMENSION:     dim_in = csr_data;
            CSR_DIAGONAL_ONLY: diag_only_in = csr_data[0];
            default:           dim_in = dim_ff;
         endcase
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_MATRIX) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.elem     = 1'b1;
                  cmd.store    = store;
                  m_in         = count_ff[IDX_W-1:0];
                  k_in         = '0;
                  diag_pend_in = 1'b1;
                  last_in      = req_last;
                  if (count_ff != DIM_W'(MAX_DIM + 1)) begin
                     count_in = count_ff + 1'b1;
                  end
                  state_in = store ? ST_RUN : ST_DRAIN;
               end
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (diag_pend_ff) begin
               cmd.diag     = 1'b1;
               diag_pend_in = 1'b0;
               if (diag_only_ff || (m_ff == '0)) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               k_in = k_ff + 1'b1;
               if (IDX_W'(k_ff + 1'b1) == m_ff) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = last_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.finish   = 1'b1;
               cmd.mismatch = (count_ff != dim_ff) || (dim_ff > DIM_W'(MAX_DIM));
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dim_ff       <= DIM_W'(1);
         diag_only_ff <= 1'b0;
         diag_pend_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dim_ff       <= dim_in;
         diag_only_ff <= diag_only_in;
         diag_pend_ff <= diag_pend_in;
         last_ff      <= last_in;
      end
      m_ff <= m_in;
      k_ff <= k_in;
   end

`ifndef ASSERT_OFF
   a_issue_in_run: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (state_ff == ST_RUN))
      else $error("term issued outside the run state");
   a_cross_below_m: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && !cmd.diag) |-> (k_ff < m_ff))
      else $error("cross term index not below element index");
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (state_ff == ST_IDLE) && (count_ff == '0))
      else $error("finish did not return to idle");
`endif

endmodule

// File: design/sbfc_datapath.sv
// Datapath of the complex symmetric bilinear form block: stores and term pipeline.
// Holds the matrix and vector memories, the accumulators and the result register;
// uses sbfc_pkg.
module sbfc_datapath import sbfc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  sbfc_cmd_type        cmd,
   output sbfc_status_type     status,
   input  logic [IDX_W-1:0]    req_row_index,
   input  logic [IDX_W-1:0]    req_col_index,
   input  logic signed [31:0]  req_matrix_value,
   input  logic signed [31:0]  req_left_real,
   input  logic signed [31:0]  req_left_imag,
   input  logic signed [31:0]  req_right_real,
   input  logic signed [31:0]  req_right_imag,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [63:0]  rsp_result_real,
   output logic signed [63:0]  rsp_result_imag,
   output logic [1:0]          rsp_status
);

   logic [31:0] mat_mem [TRI_DEPTH];
   logic [63:0] left_mem [MAX_DIM];
   logic [63:0] right_mem [MAX_DIM];

   logic [IDX_W-1:0] mrow, mcol;
   logic [TRI_W-1:0] mat_waddr, mat_raddr;

   logic [63:0]      lcur_ff, rcur_ff;
   logic [TRI_W-1:0] base_ff;
   logic [IDX_W-1:0] m_ff;

   // Stage 1: memory read data
   logic             v1_ff, d1_ff;
   logic [63:0]      lk_ff, rk_ff;
   logic [31:0]      mv1_ff;
   // Stage 2: eight partial products
   logic                v2_ff;
   logic signed [63:0]  pa0_ff, pa1_ff, pa2_ff, pa3_ff;
   logic signed [63:0]  pb0_ff, pb1_ff, pb2_ff, pb3_ff;
   logic signed [31:0]  mv2_ff;
   // Stage 3: the two conjugate products
   logic                v3_ff;
   logic signed [63:0]  are_ff, aim_ff, bre_ff, bim_ff;
   logic signed [31:0]  mv3_ff;
   // Stage 4: summed term
   logic                v4_ff;
   logic signed [63:0]  sre_ff, sim_ff;
   logic signed [31:0]  mv4_ff;
   // Stage 5: partial products of the scaling
   logic                v5_ff;
   logic signed [63:0]  hre_ff, him_ff;
   logic signed [64:0]  lre_ff, lim_ff;
   // Stage 6: exact 96-bit products
   logic                v6_ff;
   logic signed [95:0]  fre_ff, fim_ff;
   // Stage 7: scaled and clamped term
   logic                v7_ff;
   logic signed [63:0]  tre_ff, tim_ff;

   logic signed [63:0] acc_re_ff, acc_im_ff;
   logic               sat_ff;
   logic               sat_in;

   logic signed [31:0] xr, xi, yr, yi, ur, ui, wr, wi;
   logic [64:0] sa_re, sa_im, sb_re, sb_im, ss_re, ss_im, sc_re, sc_im, sac_re, sac_im;
   logic signed [79:0] qre, qim;
   logic signed [32:0] lo_re, lo_im;
   logic               f7_re, f7_im;

   assign mrow      = (req_col_index > req_row_index) ? req_col_index : req_row_index;
   assign mcol      = (req_col_index > req_row_index) ? req_row_index : req_col_index;
   assign mat_waddr = tri_base(mrow) + TRI_W'(mcol);
   assign mat_raddr = base_ff + TRI_W'(cmd.diag ? m_ff : cmd.k);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mat_mem[mat_waddr] <= req_matrix_value;
      end
      mv1_ff <= mat_mem[mat_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.elem && cmd.store) begin
         left_mem[cmd.m]  <= {req_left_imag, req_left_real};
         right_mem[cmd.m] <= {req_right_imag, req_right_real};
      end
      lk_ff <= left_mem[cmd.k];
      rk_ff <= right_mem[cmd.k];
   end

   always_ff @(posedge clock) begin
      if (cmd.elem) begin
         lcur_ff <= {req_left_imag, req_left_real};
         rcur_ff <= {req_right_imag, req_right_real};
         base_ff <= tri_base(cmd.m);
         m_ff    <= cmd.m;
      end
   end

   // conj(l)*y with y the stored right element, or the current one for the diagonal;
   // conj(lk)*r gives the second cross product and is cleared for the diagonal.
   assign xr = lcur_ff[31:0];
   assign xi = lcur_ff[63:32];
   assign yr = d1_ff ? rcur_ff[31:0] : rk_ff[31:0];
   assign yi = d1_ff ? rcur_ff[63:32] : rk_ff[63:32];
   assign ur = d1_ff ? 32'sd0 : lk_ff[31:0];
   assign ui = d1_ff ? 32'sd0 : lk_ff[63:32];
   assign wr = rcur_ff[31:0];
   assign wi = rcur_ff[63:32];

   assign sa_re = sat65({pa0_ff[63], pa0_ff} + {pa1_ff[63], pa1_ff});
   assign sa_im = sat65({pa2_ff[63], pa2_ff} - {pa3_ff[63], pa3_ff});
   assign sb_re = sat65({pb0_ff[63], pb0_ff} + {pb1_ff[63], pb1_ff});
   assign sb_im = sat65({pb2_ff[63], pb2_ff} - {pb3_ff[63], pb3_ff});
   assign ss_re = sat65({are_ff[63], are_ff} + {bre_ff[63], bre_ff});
   assign ss_im = sat65({aim_ff[63], aim_ff} + {bim_ff[63], bim_ff});

   assign lo_re = $signed({1'b0, sre_ff[31:0]});
   assign lo_im = $signed({1'b0, sim_ff[31:0]});

   // The low 16 bits drop with an arithmetic shift, which rounds towards minus infinity.
   assign qre   = fre_ff[95:16];
   assign qim   = fim_ff[95:16];
   assign f7_re = (qre[79:63] != {17{qre[63]}});
   assign f7_im = (qim[79:63] != {17{qim[63]}});

   assign sac_re = sat65({acc_re_ff[63], acc_re_ff} + {tre_ff[63], tre_ff});
   assign sac_im = sat65({acc_im_ff[63], acc_im_ff} + {tim_ff[63], tim_ff});

   assign sc_re = {f7_re, f7_re ? (qre[79] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : qre[63:0]};
   assign sc_im = {f7_im, f7_im ? (qim[79] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : qim[63:0]};

   always_ff @(posedge clock) begin
      d1_ff  <= cmd.diag;
      pa0_ff <= xr * yr;
      pa1_ff <= xi * yi;
      pa2_ff <= xr * yi;
      pa3_ff <= xi * yr;
      pb0_ff <= ur * wr;
      pb1_ff <= ui * wi;
      pb2_ff <= ur * wi;
      pb3_ff <= ui * wr;
      mv2_ff <= mv1_ff;
      are_ff <= sa_re[63:0];
      aim_ff <= sa_im[63:0];
      bre_ff <= sb_re[63:0];
      bim_ff <= sb_im[63:0];
      mv3_ff <= mv2_ff;
      sre_ff <= ss_re[63:0];
      sim_ff <= ss_im[63:0];
      mv4_ff <= mv3_ff;
      hre_ff <= $signed(sre_ff[63:32]) * mv4_ff;
      him_ff <= $signed(sim_ff[63:32]) * mv4_ff;
      lre_ff <= lo_re * mv4_ff;
      lim_ff <= lo_im * mv4_ff;
      fre_ff <= $signed({hre_ff, 32'd0}) + $signed({{31{lre_ff[64]}}, lre_ff});
      fim_ff <= $signed({him_ff, 32'd0}) + $signed({{31{lim_ff[64]}}, lim_ff});
      tre_ff <= sc_re[63:0];
      tim_ff <= sc_im[63:0];
   end

   always_comb begin
      sat_in = sat_ff;
      if (v3_ff && (ss_re[64] || ss_im[64])) sat_in = 1'b1;
      if (v2_ff && (sa_re[64] || sa_im[64] || sb_re[64] || sb_im[64])) sat_in = 1'b1;
      if (v6_ff && (f7_re || f7_im)) sat_in = 1'b1;
      if (v7_ff && (sac_re[64] || sac_im[64])) sat_in = 1'b1;
      // Handing over the result starts a fresh sum.
      if (cmd.finish) sat_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         v5_ff     <= 1'b0;
         v6_ff     <= 1'b0;
         v7_ff     <= 1'b0;
         acc_re_ff <= '0;
         acc_im_ff <= '0;
         sat_ff    <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         sat_ff <= sat_in;
         if (cmd.finish) begin
            acc_re_ff <= '0;
            acc_im_ff <= '0;
         end else if (v7_ff) begin
            acc_re_ff <= sac_re[63:0];
            acc_im_ff <= sac_im[63:0];
         end
         if (cmd.finish) begin
            rsp_valid <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_result_real <= cmd.mismatch ? 64'sd0 : acc_re_ff;
         rsp_result_imag <= cmd.mismatch ? 64'sd0 : acc_im_ff;
         rsp_status      <= cmd.mismatch ? STATUS_MISMATCH :
                            (sat_ff ? STATUS_SATURATED : STATUS_OK);
      end
   end

   assign status.pipe_busy = v1_ff | v2_ff | v3_ff | v4_ff | v5_ff | v6_ff | v7_ff;
   assign status.out_busy  = rsp_valid && rsp_stall;

`ifndef ASSERT_OFF
   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !status.pipe_busy)
      else $error("result taken while terms still in flight");
   a_finish_output: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid && (acc_re_ff == '0) && (acc_im_ff == '0) && !sat_ff)
      else $error("finish did not present a result and clear the sums");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !status.out_busy)
      else $error("result overwritten while still waiting");
`endif

endmodule

// File: design/symmetric_bilinear_form_complex.sv
// A matrix load is written on acceptance and does not stall the input. A stored vector element m
// stalls the input while its m + 1 terms issue one per cycle and the seven pipeline stages drain;
// diagonal-only mode issues only the diagonal term, and an element beyond the dimension issues
// none. The last element then hands over its result, holding the input while the previous result
// is still stalled. Synchronous active-high reset clears control, counts and sums and sets
// dimension to 1; the matrix and vector memories keep their contents.
module symmetric_bilinear_form_complex import sbfc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic [IDX_W-1:0]     req_row_index,
   input  logic [IDX_W-1:0]     req_col_index,
   input  logic signed [31:0]   req_matrix_value,
   input  logic signed [31:0]   req_left_real,
   input  logic signed [31:0]   req_left_imag,
   input  logic signed [31:0]   req_right_real,
   input  logic signed [31:0]   req_right_imag,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [63:0]   rsp_result_real,
   output logic signed [63:0]   rsp_result_imag,
   output logic [1:0]           rsp_status,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   sbfc_cmd_type    cmd;
   sbfc_status_type status;

   sbfc_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_last         (req_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .status           (status),
      .cmd              (cmd)
   );

   sbfc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_matrix_value (req_matrix_value),
      .req_left_real    (req_left_real),
      .req_left_imag    (req_left_imag),
      .req_right_real   (req_right_real),
      .req_right_imag   (req_right_imag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_real  (rsp_result_real),
      .rsp_result_imag  (rsp_result_imag),
      .rsp_status       (rsp_status)
   );

endmodule
